[src/pfa_pkg.sv]
// shared constants, types and codes for the two-objective pareto archive
package pfa_pkg;

    localparam int TABLE_DEPTH   = 64;
    localparam int FRACTION_BITS = 16;

    localparam int IN_W      = 16;
    localparam int TAG_W     = 16;
    localparam int OUT_CNT_W = 7;
    localparam int VAL_W     = (FRACTION_BITS + 1 > IN_W) ? FRACTION_BITS + 1 : IN_W;
    localparam int IDX_W     = $clog2(TABLE_DEPTH);
    localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W   = 2 * VAL_W + TAG_W;

    localparam logic [VAL_W-1:0] VAL_ZERO = '0;
    localparam logic [VAL_W-1:0] VAL_ONE  = VAL_W'(1) << FRACTION_BITS;
    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(2);

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_EQUAL     = 2'd1,
        ST_DOMINATED = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_INIT0,
        S_INIT1,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_COPY,
        S_WRITE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic init_wr;
        logic init_sel;
        logic accept;
        logic scan;
        logic decide;
        logic copy;
        logic write_new;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic dec_insert;
        logic copy_done;
        logic out_free;
    } dp_status_t;

endpackage

[src/pfa_ram.sv]
// generic single write port, single read port ram with registered read
module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/pfa_ctrl.sv]
// sequencer for sentinel init, scan, decision, compaction and result beat
module pfa_ctrl
    import pfa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t st,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_INIT0:
            begin
                cmd.init_wr  = 1'b1;
                cmd.init_sel = 1'b0;
                state_next   = S_INIT1;
            end
            S_INIT1:
            begin
                cmd.init_wr  = 1'b1;
                cmd.init_sel = 1'b1;
                state_next   = S_IDLE;
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (st.scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = st.dec_insert ? S_COPY : S_OUT;
            end
            S_COPY:
            begin
                cmd.copy = 1'b1;
                if (st.copy_done)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.write_new = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT0;
            end
        endcase
    end

endmodule

[src/pfa_datapath.sv]
// point table, scan compare, removal count, compaction moves and result register
module pfa_datapath
    import pfa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output dp_status_t           st,
    input  logic [IN_W-1:0]      first_objective,
    input  logic [IN_W-1:0]      second_objective,
    input  logic [TAG_W-1:0]     solution_tag,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           status,
    output logic [OUT_CNT_W-1:0] removed_count,
    output logic [OUT_CNT_W-1:0] occupancy
);

    logic [VAL_W-1:0]     e1_reg, e1_next;
    logic [VAL_W-1:0]     e2_reg, e2_next;
    logic [TAG_W-1:0]     tag_reg, tag_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [CNT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]     chk_idx_reg, chk_idx_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic [CNT_W-1:0]     p_reg, p_next;
    logic [CNT_W-1:0]     lo_reg, lo_next;
    logic                 lo_found_reg, lo_found_next;
    logic                 later_reg, later_next;
    logic                 equal_reg, equal_next;
    logic                 dom_reg, dom_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]     left_reg, left_next;
    logic                 up_reg, up_next;
    logic [CNT_W-1:0]     offset_reg, offset_next;
    logic                 wr_vld_reg, wr_vld_next;
    logic [CNT_W-1:0]     wr_src_reg, wr_src_next;
    status_t              res_status_reg, res_status_next;
    logic [CNT_W-1:0]     res_removed_reg, res_removed_next;
    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    logic [OUT_CNT_W-1:0] out_removed_reg, out_removed_next;
    logic [OUT_CNT_W-1:0] out_occ_reg, out_occ_next;

    logic                 ram_wr_en;
    logic [IDX_W-1:0]     ram_wr_addr;
    logic [ENTRY_W-1:0]   ram_wr_data;
    logic                 ram_rd_en;
    logic [ENTRY_W-1:0]   ram_rd_data;

    logic [VAL_W-1:0]     rd_first;
    logic [VAL_W-1:0]     rd_second;
    logic                 issue;
    logic                 below;
    logic                 hit;
    logic                 scan_done;
    logic [CNT_W-1:0]     lo_eff;
    logic [CNT_W-1:0]     removed;
    logic [CNT_W-1:0]     remain;
    status_t              dec_status;
    logic [CNT_W-1:0]     wr_dst;

    pfa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_idx_reg[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign rd_first  = ram_rd_data[ENTRY_W-1 -: VAL_W];
    assign rd_second = ram_rd_data[ENTRY_W-VAL_W-1 -: VAL_W];

    // scan compare on the beat of data returning from the table
    assign issue     = (rd_idx_reg < n_reg);
    assign below     = (rd_first < e1_reg) || ((rd_first == e1_reg) && (rd_second < e2_reg));
    assign hit       = chk_vld_reg && !below;
    assign scan_done = hit || (!chk_vld_reg && !issue);

    // decision
    assign lo_eff  = lo_found_reg ? lo_reg : p_reg;
    assign removed = p_reg - lo_eff;
    assign remain  = n_reg - removed;

    always_comb
    begin
        if (later_reg && equal_reg)
        begin
            dec_status = ST_EQUAL;
        end
        else if (later_reg && dom_reg)
        begin
            dec_status = ST_DOMINATED;
        end
        else if (remain >= CNT_DEPTH)
        begin
            dec_status = ST_FULL;
        end
        else
        begin
            dec_status = ST_INSERTED;
        end
    end

    assign wr_dst = wr_src_reg + offset_reg;

    assign st.scan_done  = scan_done;
    assign st.dec_insert = (dec_status == ST_INSERTED);
    assign st.copy_done  = (left_reg == '0) && !wr_vld_reg;
    assign st.out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        e1_next          = e1_reg;
        e2_next          = e2_reg;
        tag_next         = tag_reg;
        n_next           = n_reg;
        rd_idx_next      = rd_idx_reg;
        chk_idx_next     = chk_idx_reg;
        chk_vld_next     = chk_vld_reg;
        p_next           = p_reg;
        lo_next          = lo_reg;
        lo_found_next    = lo_found_reg;
        later_next       = later_reg;
        equal_next       = equal_reg;
        dom_next         = dom_reg;
        rem_next         = rem_reg;
        left_next        = left_reg;
        up_next          = up_reg;
        offset_next      = offset_reg;
        wr_vld_next      = wr_vld_reg;
        wr_src_next      = wr_src_reg;
        res_status_next  = res_status_reg;
        res_removed_next = res_removed_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_removed_next = out_removed_reg;
        out_occ_next     = out_occ_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = '0;
        ram_wr_data      = '0;
        ram_rd_en        = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.init_wr)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = IDX_W'(cmd.init_sel);
            ram_wr_data = cmd.init_sel ? {VAL_ONE, VAL_ZERO, TAG_W'(0)}
                                       : {VAL_ZERO, VAL_ONE, TAG_W'(0)};
        end

        if (cmd.accept)
        begin
            e1_next       = VAL_W'(first_objective);
            e2_next       = VAL_W'(second_objective);
            tag_next      = solution_tag;
            rd_idx_next   = '0;
            chk_vld_next  = 1'b0;
            lo_found_next = 1'b0;
        end

        if (cmd.scan)
        begin
            ram_rd_en    = issue;
            chk_vld_next = issue;
            chk_idx_next = rd_idx_reg;
            if (issue)
            begin
                rd_idx_next = rd_idx_reg + CNT_W'(1);
            end
            if (chk_vld_reg && below && (rd_second <= e2_reg) && !lo_found_reg)
            begin
                lo_next       = chk_idx_reg;
                lo_found_next = 1'b1;
            end
            if (hit)
            begin
                p_next     = chk_idx_reg;
                later_next = 1'b1;
                equal_next = (rd_first == e1_reg) && (rd_second == e2_reg);
                dom_next   = (e2_reg <= rd_second);
            end
            else if (scan_done)
            begin
                p_next     = n_reg;
                later_next = 1'b0;
            end
        end

        if (cmd.decide)
        begin
            res_status_next  = dec_status;
            res_removed_next = (dec_status == ST_INSERTED) ? removed : '0;
            lo_next          = lo_eff;
            rem_next         = removed;
            left_next        = n_reg - p_reg;
            up_next          = (removed == '0);
            rd_idx_next      = (removed == '0) ? n_reg - CNT_W'(1) : p_reg;
            offset_next      = lo_eff + CNT_W'(1) - p_reg;
            wr_vld_next      = 1'b0;
        end

        if (cmd.copy)
        begin
            ram_rd_en   = (left_reg != '0);
            wr_vld_next = (left_reg != '0);
            wr_src_next = rd_idx_reg;
            if (left_reg != '0)
            begin
                left_next   = left_reg - CNT_W'(1);
                rd_idx_next = up_reg ? rd_idx_reg - CNT_W'(1) : rd_idx_reg + CNT_W'(1);
            end
            if (wr_vld_reg)
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = wr_dst[IDX_W-1:0];
                ram_wr_data = ram_rd_data;
            end
        end

        if (cmd.write_new)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = lo_reg[IDX_W-1:0];
            ram_wr_data = {e1_reg, e2_reg, tag_reg};
            n_next      = n_reg - rem_reg + CNT_W'(1);
        end

        if (cmd.load_out)
        begin
            out_valid_next   = 1'b1;
            out_status_next  = res_status_reg;
            out_removed_next = OUT_CNT_W'(res_removed_reg);
            out_occ_next     = OUT_CNT_W'(n_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= CNT_RESET;
            out_valid_reg <= 1'b0;
            chk_vld_reg   <= 1'b0;
            lo_found_reg  <= 1'b0;
            wr_vld_reg    <= 1'b0;
            left_reg      <= '0;
        end
        else
        begin
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
            chk_vld_reg   <= chk_vld_next;
            lo_found_reg  <= lo_found_next;
            wr_vld_reg    <= wr_vld_next;
            left_reg      <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e1_reg          <= e1_next;
        e2_reg          <= e2_next;
        tag_reg         <= tag_next;
        rd_idx_reg      <= rd_idx_next;
        chk_idx_reg     <= chk_idx_next;
        p_reg           <= p_next;
        lo_reg          <= lo_next;
        later_reg       <= later_next;
        equal_reg       <= equal_next;
        dom_reg         <= dom_next;
        rem_reg         <= rem_next;
        up_reg          <= up_next;
        offset_reg      <= offset_next;
        wr_src_reg      <= wr_src_next;
        res_status_reg  <= res_status_next;
        res_removed_reg <= res_removed_next;
        out_status_reg  <= out_status_next;
        out_removed_reg <= out_removed_next;
        out_occ_reg     <= out_occ_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign removed_count = out_removed_reg;
    assign occupancy     = out_occ_reg;

endmodule

[src/pareto_front_archive_2d_top.sv]
// top level of the two-objective pareto archive
// The block holds up to 64 mutually non-dominated points (both objectives
// maximized, Q0.16) in a single table RAM sorted by first objective, and
// answers every input point with one result beat. One point is in work at a
// time: a point is accepted, then the table is scanned from its first
// entry up to the first entry at or after the point, one table read per
// cycle through the RAM read port, and a decision is made; when the point
// is inserted, the tail of the table is moved through the same read and
// write ports and the point is stored; last the result register is loaded.
// A rejected point skips the move and the store. The result register lets
// the next point be accepted while a result beat is still stalled. After
// reset the block writes the two sentinel points into the table before it
// accepts its first point.
module pareto_front_archive_2d_top
    import pfa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [IN_W-1:0]      first_objective,
    input  logic [IN_W-1:0]      second_objective,
    input  logic [TAG_W-1:0]     solution_tag,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           status,
    output logic [OUT_CNT_W-1:0] removed_count,
    output logic [OUT_CNT_W-1:0] occupancy
);

    cmd_t       cmd;
    dp_status_t st;

    pfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    pfa_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .st               (st),
        .first_objective  (first_objective),
        .second_objective (second_objective),
        .solution_tag     (solution_tag),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .removed_count    (removed_count),
        .occupancy        (occupancy)
    );

endmodule

[src/pfa_checker.sv]
// port-level checks for the pareto archive and their bind to the top level
module pfa_checker
    import pfa_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic [IN_W-1:0]      first_objective,
    input logic [IN_W-1:0]      second_objective,
    input logic [TAG_W-1:0]     solution_tag,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [1:0]           status,
    input logic [OUT_CNT_W-1:0] removed_count,
    input logic [OUT_CNT_W-1:0] occupancy
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(removed_count) && $stable(occupancy))
        else $error("stalled result beat changed");

    // one point in work at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input beat accepted while a point is in work");

    // rejected points remove nothing
    a_reject_no_removal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_INSERTED) |-> removed_count == '0)
        else $error("removal reported on a rejected point");

    // full table rejection only with every slot taken
    a_full_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> occupancy == OUT_CNT_W'(TABLE_DEPTH))
        else $error("table full reported below full occupancy");

endmodule

bind pareto_front_archive_2d_top pfa_checker u_pfa_checker (.*);

[test/tb_pareto_front_archive_2d_top.sv]
// testbench for the pareto archive: front predictor in a scoreboard class, drivers and checks
module tb_pareto_front_archive_2d_top;
    import pfa_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int ITEM_TARGET  = 700;
    localparam int MAX_LEVEL    = 131070;

    typedef struct packed {
        status_t                status;
        logic [OUT_CNT_W-1:0]   removed;
        logic [OUT_CNT_W-1:0]   occupancy;
    } archive_result_t;

    class front_scoreboard;
        logic [VAL_W-1:0] firsts[TABLE_DEPTH];
        logic [VAL_W-1:0] seconds[TABLE_DEPTH];
        logic [TAG_W-1:0] tags[TABLE_DEPTH];
        int entries;
        archive_result_t expected_results[$];
        int mismatches;

        function new();
            firsts[0]  = VAL_ZERO;
            seconds[0] = VAL_ONE;
            firsts[1]  = VAL_ONE;
            seconds[1] = VAL_ZERO;
            entries    = 2;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // a point now on the front, sentinels left out
        function void stored_point(output logic [IN_W-1:0] a, output logic [IN_W-1:0] b);
            int idx;
            idx = $urandom_range(1, entries - 2);
            a = firsts[idx][IN_W-1:0];
            b = seconds[idx][IN_W-1:0];
        endfunction

        function void note_point(logic [IN_W-1:0] a, logic [IN_W-1:0] b,
                                 logic [TAG_W-1:0] t);
            logic [VAL_W-1:0] e1;
            logic [VAL_W-1:0] e2;
            int p;
            int lo;
            int removed;
            int tail;
            archive_result_t r;
            e1 = VAL_W'(a);
            e2 = VAL_W'(b);
            p = 0;
            while (p < entries && (firsts[p] < e1 || (firsts[p] == e1 && seconds[p] < e2)))
                p++;
            r.removed = '0;
            if (p < entries && firsts[p] == e1 && seconds[p] == e2)
                r.status = ST_EQUAL;
            else if (p < entries && e2 <= seconds[p])
                r.status = ST_DOMINATED;
            else
            begin
                lo = p;
                while (lo > 0 && seconds[lo-1] <= e2)
                    lo--;
                removed = p - lo;
                if (entries - removed >= TABLE_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    tail = entries - p;
                    // tail moves up by one when nothing is removed, otherwise down by one less than the removed count
                    if (lo == p)
                    begin
                        for (int i = tail - 1; i >= 0; i--)
                        begin
                            firsts[lo+1+i]  = firsts[p+i];
                            seconds[lo+1+i] = seconds[p+i];
                            tags[lo+1+i]    = tags[p+i];
                        end
                    end
                    else
                    begin
                        for (int i = 0; i < tail; i++)
                        begin
                            firsts[lo+1+i]  = firsts[p+i];
                            seconds[lo+1+i] = seconds[p+i];
                            tags[lo+1+i]    = tags[p+i];
                        end
                    end
                    firsts[lo]  = e1;
                    seconds[lo] = e2;
                    tags[lo]    = t;
                    entries     = entries - removed + 1;
                    r.status    = ST_INSERTED;
                    r.removed   = OUT_CNT_W'(removed);
                end
            end
            r.occupancy = OUT_CNT_W'(entries);
            expected_results = {expected_results, r};
        endfunction

        function void check_result(logic [1:0] st, logic [OUT_CNT_W-1:0] rem,
                                   logic [OUT_CNT_W-1:0] occ);
            archive_result_t want;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: status %0d removed %0d occupancy %0d",
                             st, rem, occ);
                return;
            end
            want = expected_results.pop_front();
            if (st !== want.status || rem !== want.removed || occ !== want.occupancy)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: status %0d/%0d removed %0d/%0d occupancy %0d/%0d %s",
                             want.status, st, want.removed, rem, want.occupancy, occ,
                             "(expected/actual)");
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [IN_W-1:0]      first_objective;
    logic [IN_W-1:0]      second_objective;
    logic [TAG_W-1:0]     solution_tag;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           status;
    logic [OUT_CNT_W-1:0] removed_count;
    logic [OUT_CNT_W-1:0] occupancy;

    front_scoreboard front_sb;
    int idle_pct;
    int stall_pct;
    int points_sent;
    int points_accepted = 0;
    logic hold_off = 1'b0;

    pareto_front_archive_2d_top u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .first_objective  (first_objective),
        .second_objective (second_objective),
        .solution_tag     (solution_tag),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .removed_count    (removed_count),
        .occupancy        (occupancy)
    );

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            front_sb.note_point(first_objective, second_objective, solution_tag);
            points_accepted <= points_accepted + 1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            front_sb.check_result(status, removed_count, occupancy);
    end

    always @(posedge clk)
        out_stall <= hold_off || ($urandom_range(0, 99) < stall_pct);

    // long receiver hold-off so the block backs up into its input
    initial
    begin
        wait (points_accepted >= 350);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (600) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_point(input logic [IN_W-1:0] a, input logic [IN_W-1:0] b,
                              input logic [TAG_W-1:0] t);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid         <= 1'b1;
        first_objective  <= a;
        second_objective <= b;
        solution_tag     <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        points_sent++;
    endtask

    // points near the line first + second = level, mixed with repeats and noise
    task automatic drive_front(input int count, input int level, input int jitter);
        int lo_a;
        int hi_a;
        int a;
        int b;
        int pick;
        logic [IN_W-1:0] sa;
        logic [IN_W-1:0] sb;
        lo_a = (level > 65535) ? level - 65535 : 0;
        hi_a = (level < 65535) ? level : 65535;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10 && front_sb.entries > 2)
            begin
                front_sb.stored_point(sa, sb);
                send_point(sa, sb, TAG_W'($urandom()));
            end
            else if (pick < 18)
                send_point(IN_W'($urandom()), IN_W'($urandom()), TAG_W'($urandom()));
            else
            begin
                a = $urandom_range(lo_a, hi_a);
                b = level - a + int'($urandom_range(0, 2 * jitter)) - jitter;
                if (pick < 24)
                    b = b - 3000;
                if (b < 0)
                    b = 0;
                if (b > 65535)
                    b = 65535;
                send_point(IN_W'(a), IN_W'(b), TAG_W'($urandom()));
            end
        end
    endtask

    initial
    begin
        int level;
        int count;
        int episode;
        front_sb         = new();
        idle_pct         = 0;
        stall_pct        = 0;
        points_sent      = 0;
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        first_objective  = '0;
        second_objective = '0;
        solution_tag     = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_point(16'd0, 16'd0, 16'h0000);
        send_point(16'd0, 16'hFFFF, 16'hFFFF);
        send_point(16'hFFFF, 16'd0, 16'hAAAA);
        send_point(16'd100, 16'd100, 16'h5555);
        send_point(16'd100, 16'd100, 16'h0001);
        send_point(16'd50, 16'd50, 16'h0002);
        send_point(16'd100, 16'd50, 16'h0003);
        send_point(16'd200, 16'd80, 16'h0004);
        send_point(16'd150, 16'd120, 16'h0005);
        send_point(16'd300, 16'd300, 16'h0006);
        send_point(16'hFFFF, 16'd1, 16'h0007);
        send_point(16'd1, 16'hFFFF, 16'h0008);
        send_point(16'hFFFF, 16'd1, 16'h0009);
        send_point(16'hFFFF, 16'd0, 16'h000A);
        send_point(16'h8000, 16'h8000, 16'h000B);

        level   = 70000;
        episode = 0;
        while (points_sent < ITEM_TARGET)
        begin
            case (episode % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 48; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 48; end
                default: begin idle_pct = 23; stall_pct = 23; end
            endcase
            count = (episode == 0) ? 90 : $urandom_range(20, 90);
            if (count > ITEM_TARGET - points_sent)
                count = ITEM_TARGET - points_sent;
            drive_front(count, level, (episode % 3 == 0) ? 0 : $urandom_range(1, 400));
            level = level + $urandom_range(1500, 6000);
            if (level > MAX_LEVEL)
                level = MAX_LEVEL;
            episode++;
        end

        idle_pct = 0;
        send_point(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_point(16'hFFFF, 16'hFFFF, 16'h0000);
        send_point(16'hFFFE, 16'hFFFF, 16'h1234);
        in_valid <= 1'b0;

        while (front_sb.pending() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (front_sb.mismatches == 0 && front_sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
src/pfa_pkg.sv
src/pfa_ram.sv
src/pfa_ctrl.sv
src/pfa_datapath.sv
src/pareto_front_archive_2d_top.sv
src/pfa_checker.sv
test/tb_pareto_front_archive_2d_top.sv
